>>> rtl/hmr_pkg.sv
// types and constants shared by the histogram median block
package hmr_pkg;

    localparam int BIN_BITS = 8;

    typedef struct packed {
        logic [BIN_BITS-1:0] sample_bin;
        logic                in_range;
        logic                last_sample;
    } sample_t;

    typedef struct packed {
        logic [BIN_BITS-1:0] median_bin;
        logic                found;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_ACCUM,
        ST_DRAIN,
        ST_SCAN,
        ST_FINISH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic take;
        logic sweep;
        logic scan;
        logic drain;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic out_free;
    } status_t;

endpackage

>>> rtl/hmr_ctrl.sv
// controller state machine of the histogram median block
module hmr_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sample_valid,
    input  logic            last_sample,
    input  hmr_pkg::status_t status,
    output logic            sample_stall,
    output hmr_pkg::cmd_t   cmd
);
    import hmr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                if (sample_valid && last_sample)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        sample_stall = 1'b1;
        cmd          = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep = 1'b1;
            end
            ST_ACCUM:
            begin
                sample_stall = 1'b0;
                cmd.take     = sample_valid;
            end
            ST_DRAIN:
            begin
                cmd.drain = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.sweep = 1'b1;
                cmd.scan  = 1'b1;
            end
            ST_FINISH:
            begin
                cmd = '0;
            end
            ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/hmr_datapath.sv
// histogram memory, counters, scan accumulator and result register
module hmr_datapath
#(
    parameter int NUM_BINS   = 256,
    parameter int COUNT_BITS = 20
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  hmr_pkg::cmd_t    cmd,
    input  hmr_pkg::sample_t sample_data,
    input  logic             result_stall,
    output logic             result_valid,
    output hmr_pkg::result_t result_data,
    output hmr_pkg::status_t status
);
    import hmr_pkg::*;

    localparam int ADDR_BITS = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [ADDR_BITS-1:0]  LAST_ADDR = ADDR_BITS'(NUM_BINS - 1);

    logic [COUNT_BITS-1:0] mem [NUM_BINS];

    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  s1_valid_reg;
    logic [ADDR_BITS-1:0]  s1_addr_reg;
    logic                  lw_valid_reg;
    logic [ADDR_BITS-1:0]  lw_addr_reg;
    logic [COUNT_BITS-1:0] lw_data_reg;
    logic [ADDR_BITS-1:0]  sweep_addr_reg;
    logic [ADDR_BITS-1:0]  dv_addr_reg;
    logic                  dv_valid_reg;
    logic [COUNT_BITS-1:0] total_reg;
    logic [COUNT_BITS-2:0] half_reg;
    logic [COUNT_BITS-2:0] running_reg;
    logic                  found_reg;
    logic [BIN_BITS-1:0]   median_reg;
    logic                  result_valid_reg;
    result_t               result_reg;

    logic                  in_bounds;
    logic                  counted;
    logic [ADDR_BITS-1:0]  sample_addr;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic [COUNT_BITS-1:0] inc_base;
    logic [COUNT_BITS-1:0] inc_value;
    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic [COUNT_BITS:0]   scan_sum;
    logic                  out_free;

    assign in_bounds   = (32'(sample_data.sample_bin) < NUM_BINS);
    assign counted     = cmd.take && sample_data.in_range && in_bounds;
    assign sample_addr = ADDR_BITS'(sample_data.sample_bin);
    assign rd_addr     = cmd.take ? sample_addr : sweep_addr_reg;

    // forward the previous increment when the same bin follows
    assign inc_base  = (lw_valid_reg && (lw_addr_reg == s1_addr_reg)) ? lw_data_reg
                                                                      : rd_data_reg;
    assign inc_value = (inc_base == COUNT_MAX) ? COUNT_MAX : inc_base + 1'b1;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = sweep_addr_reg;
        wr_data = '0;
        priority if (s1_valid_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = s1_addr_reg;
            wr_data = inc_value;
        end
        else if (cmd.sweep)
        begin
            wr_en = 1'b1;
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            lw_valid_reg   <= 1'b0;
            sweep_addr_reg <= '0;
            dv_valid_reg   <= 1'b0;
            total_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= counted;
            lw_valid_reg <= s1_valid_reg;
            dv_valid_reg <= cmd.scan;
            if (cmd.sweep)
            begin
                sweep_addr_reg <= (sweep_addr_reg == LAST_ADDR) ? '0
                                                                : sweep_addr_reg + 1'b1;
            end
            if (cmd.drain)
            begin
                total_reg <= '0;
            end
            else if (cmd.take && (total_reg != COUNT_MAX))
            begin
                total_reg <= total_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= sample_addr;
        lw_addr_reg <= s1_addr_reg;
        lw_data_reg <= inc_value;
        dv_addr_reg <= sweep_addr_reg;
    end

    assign scan_sum = (COUNT_BITS+1)'(running_reg) + (COUNT_BITS+1)'(rd_data_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.drain)
        begin
            half_reg    <= total_reg[COUNT_BITS-1:1];
            running_reg <= '0;
            found_reg   <= 1'b0;
            median_reg  <= '0;
        end
        else if (dv_valid_reg && !found_reg)
        begin
            running_reg <= scan_sum[COUNT_BITS-2:0];
            if (scan_sum > (COUNT_BITS+1)'(half_reg))
            begin
                found_reg  <= 1'b1;
                median_reg <= BIN_BITS'(dv_addr_reg);
            end
        end
    end

    assign out_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.median_bin <= median_reg;
            result_reg.found      <= found_reg;
        end
    end

    assign result_valid      = result_valid_reg;
    assign result_data       = result_reg;
    assign status.sweep_last = (sweep_addr_reg == LAST_ADDR);
    assign status.out_free   = out_free;

endmodule

>>> rtl/histogram_median_of_region.sv
// top level of the histogram median block
//
// samples of one region arrive on the sample channel (valid/stall), one
// transaction per sample; the median comes out on the result channel
// (valid/stall), one transaction per region
// while collecting, a sample is taken every cycle: a read-modify-write of
// one histogram memory word with forwarding between neighboring samples
// after the sample marked last the block stalls the sample channel while
// the last count lands, the memory is scanned one bin per cycle
// (clearing each bin as it is read), the sum is finished and the result
// register is loaded
// if the result register is still held by a stall, the block waits with
// the sample channel stalled until it frees up
// after reset the block clears the histogram memory, one bin per cycle,
// while stalling the sample channel
module histogram_median_of_region
#(
    parameter int NUM_BINS   = 256,
    parameter int COUNT_BITS = 20
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  hmr_pkg::sample_t sample_data,
    output logic             result_valid,
    input  logic             result_stall,
    output hmr_pkg::result_t result_data
);
    import hmr_pkg::*;

    cmd_t    cmd;
    status_t status;

    hmr_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .last_sample  (sample_data.last_sample),
        .status       (status),
        .sample_stall (sample_stall),
        .cmd          (cmd)
    );

    hmr_datapath
    #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sample_data  (sample_data),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result_data  (result_data),
        .status       (status)
    );

endmodule

>>> rtl/hmr_checker.sv
// port-level checks of the histogram median block and their binding
module hmr_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             sample_valid,
    input logic             sample_stall,
    input hmr_pkg::sample_t sample_data,
    input logic             result_valid,
    input logic             result_stall,
    input hmr_pkg::result_t result_data
);
    import hmr_pkg::*;

    // a stalled result transaction stays
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

    // no median reported when nothing was found
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_data.found |-> result_data.median_bin == '0)
    else $error("median bin set without a find");

    // the last sample of a region closes the sample channel
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall && sample_data.last_sample |=> sample_stall)
    else $error("sample taken during scan");

    // a new result only appears after the sample channel was held off
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_stall))
    else $error("result loaded while collecting");

endmodule

bind histogram_median_of_region hmr_checker u_hmr_checker (.*);
